@@ rtl/tcm_pkg.sv @@
// Shared constants and types for the two-point touch calibration mapper.
`default_nettype none
package tcm_pkg;

  localparam int ScreenWidth  = 320;
  localparam int ScreenHeight = 240;
  localparam int RawMax       = 4095;
  localparam int FracBits     = 20;

  localparam int RawW   = 12;
  localparam int PixXW  = 9;
  localparam int PixYW  = 8;
  localparam int ScaleW = 32;
  localparam int OffW   = 44;
  // Dividend width for the scale division: (W-1) << FracBits.
  localparam int NumW   = 33;
  localparam int QW     = NumW;

  localparam logic OpPoll  = 1'b0;
  localparam logic OpStart = 1'b1;

  typedef struct packed {
    logic             operation;
    logic             touched;
    logic [RawW-1:0]  raw_x;
    logic [RawW-1:0]  raw_y;
  } tcm_in_t;

  typedef struct packed {
    logic              pressed;
    logic [PixXW-1:0]  pixel_x;
    logic [PixYW-1:0]  pixel_y;
    logic              calibrating;
    logic              calibration_done;
  } tcm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the input item
    logic cap_first;   // capture first corner
    logic cap_second;  // capture second corner
    logic div_start;   // start scale division on axis
    logic div_axis;    // 0 = x, 1 = y
    logic div_commit;  // write scale and offset
    logic map_start;   // start mapping of latched sample
  } tcm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic map_busy;
  } tcm_sts_t;

endpackage
`default_nettype wire

@@ rtl/tcm_if.sv @@
// Valid/ready channel interface carrying one item of a given payload type.
`default_nettype none
interface tcm_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tcm_datapath.sv @@
// Datapath: corner capture, iterative scale divider, offset and mapping arithmetic.
`default_nettype none
module tcm_datapath
  import tcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcm_in_t          in_item,
  input  wire tcm_cmd_t         cmd,
  output tcm_sts_t              sts,
  output logic [PixXW-1:0]      pix_x,
  output logic [PixYW-1:0]      pix_y
);

  localparam logic [5:0] DivSteps = 6'(QW);

  tcm_in_t item;
  logic [RawW-1:0] fx, fy, sx, sy;
  logic signed [ScaleW-1:0] x_scale, y_scale;
  logic signed [OffW-1:0]   x_offset, y_offset;

  // Restoring divider state.
  logic [5:0]        div_cnt;
  logic              div_run;
  logic              div_axis;
  logic              div_neg;
  logic [RawW-1:0]   div_d;
  logic [NumW-1:0]   div_num;
  logic [RawW:0]     div_rem;
  logic [QW-1:0]     div_q;
  logic [RawW:0]     rem_sh;
  logic [RawW:0]     rem_sub;
  logic              ge;

  // Mapping: two multiply steps, x then y.
  logic [2:0]        map_ph;
  logic signed [49:0] prod;
  logic signed [49:0] acc;
  logic [20:0]       quot_sum;

  logic signed [RawW:0] dx, dy, dsel;
  logic [RawW-1:0] ad;
  logic [QW:0]     q_rnd;
  logic signed [ScaleW-1:0] scale_new;

  assign dx = $signed({1'b0, sx}) - $signed({1'b0, fx});
  assign dy = $signed({1'b0, sy}) - $signed({1'b0, fy});
  assign dsel = cmd.div_axis ? dy : dx;
  assign ad = dsel[RawW] ? RawW'(-dsel) : dsel[RawW-1:0];

  assign rem_sh  = {div_rem[RawW-1:0], div_num[NumW-1]};
  assign ge      = rem_sh >= {1'b0, div_d};
  assign rem_sub = ge ? rem_sh - {1'b0, div_d} : rem_sh;

  // Calibrated map: product plus offset plus one half, for the axis in progress.
  assign acc = prod + ((map_ph == 3'd2) ? 50'(x_offset) : 50'(y_offset))
               + 50'(1 << (FracBits-1));

  // Division by RawMax = 2^12 - 1: (x + (x >> 12) + 1) >> 12 is exact while the
  // quotient stays well below 4096.
  assign quot_sum = prod[20:0] + 21'(prod[20:12]) + 21'd1;

  always_comb begin
    q_rnd = {1'b0, div_q};
    if (div_neg) begin
      scale_new = (q_rnd > (QW+1)'(33'h80000000)) ? 32'sh80000000
                                                 : ScaleW'(-q_rnd);
    end else begin
      scale_new = (q_rnd > (QW+1)'(33'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                 : ScaleW'(q_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fx <= '0; fy <= '0; sx <= '0; sy <= '0;
      x_scale <= '0; y_scale <= '0; x_offset <= '0; y_offset <= '0;
      div_run <= 1'b0;
      div_cnt <= '0;
      map_ph <= '0;
    end else begin
      if (cmd.load) item <= in_item;
      if (cmd.cap_first) begin
        fx <= item.raw_x; fy <= item.raw_y;
      end
      if (cmd.cap_second) begin
        sx <= item.raw_x; sy <= item.raw_y;
      end
      if (cmd.div_start) begin
        // Numerator gets half the divisor added for round-half-away.
        div_axis <= cmd.div_axis;
        div_neg  <= dsel[RawW];
        div_d    <= ad;
        div_num  <= (cmd.div_axis ? NumW'(ScreenHeight-1) : NumW'(ScreenWidth-1))
                    * NumW'(1 << FracBits) + NumW'(ad >> 1);
        div_rem  <= '0;
        div_q    <= '0;
        div_cnt  <= DivSteps;
        div_run  <= 1'b1;
      end else if (div_run) begin
        div_rem <= rem_sub;
        div_q   <= {div_q[QW-2:0], ge};
        div_num <= {div_num[NumW-2:0], 1'b0};
        div_cnt <= div_cnt - 6'd1;
        if (div_cnt == 6'd1) div_run <= 1'b0;
      end
      // An axis whose corners coincide keeps its previous mapping.
      if (cmd.div_commit && (div_d != '0)) begin
        if (div_axis) begin
          y_scale  <= scale_new;
          y_offset <= OffW'(-($signed({1'b0, fy}) * scale_new));
        end else begin
          x_scale  <= scale_new;
          x_offset <= OffW'(-($signed({1'b0, fx}) * scale_new));
        end
      end
      // Map sequence: ph1 multiply x, ph2 finish x, ph3 multiply y, ph4 finish y.
      if (cmd.map_start) map_ph <= 3'd1;
      else if (map_ph != 3'd0) map_ph <= (map_ph == 3'd4) ? 3'd0 : map_ph + 3'd1;
      unique case (map_ph)
        3'd1: begin
          if (x_scale == 0) prod <= 50'(item.raw_x) * 50'(ScreenWidth-1);
          else prod <= $signed({38'd0, item.raw_x}) * 50'(x_scale);
        end
        3'd2: begin
          if (x_scale == 0) pix_x <= PixXW'(quot_sum[20:12]);
          else begin
            if (acc < 0) pix_x <= '0;
            else if ((acc >>> FracBits) >= 50'(ScreenWidth)) pix_x <= PixXW'(ScreenWidth-1);
            else pix_x <= PixXW'(acc >>> FracBits);
          end
        end
        3'd3: begin
          if (y_scale == 0) prod <= 50'(item.raw_y) * 50'(ScreenHeight-1);
          else prod <= $signed({38'd0, item.raw_y}) * 50'(y_scale);
        end
        3'd4: begin
          if (y_scale == 0) pix_y <= PixYW'(quot_sum[20:12]);
          else begin
            if (acc < 0) pix_y <= '0;
            else if ((acc >>> FracBits) >= 50'(ScreenHeight)) pix_y <= PixYW'(ScreenHeight-1);
            else pix_y <= PixYW'(acc >>> FracBits);
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.div_busy = div_run | cmd.div_start;
  assign sts.map_busy = (map_ph != 3'd0) | cmd.map_start;

endmodule
`default_nettype wire

@@ rtl/tcm_ctrl.sv @@
// Controller: calibration phase tracking and per-item sequencing.
`default_nettype none
module tcm_ctrl
  import tcm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tcm_in_t   in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic           out_pressed,
  output logic           out_cal,
  output logic           out_done,
  input  wire tcm_sts_t  sts,
  output tcm_cmd_t       cmd
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TL_PRESS, PH_TL_RELEASE, PH_BR_PRESS, PH_BR_RELEASE
  } phase_t;

  typedef enum logic [2:0] {
    S_READY, S_DIVX, S_DIVY, S_WAITY, S_MAP, S_OUT
  } state_t;

  phase_t phase;
  state_t state;
  logic   started;
  logic   accept;

  assign in_ready = (state == S_READY) && !out_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load = accept;
    if (state == S_DIVX && !started) begin
      cmd.div_start = 1'b1;
    end
    if (state == S_DIVX && started && !sts.div_busy) cmd.div_commit = 1'b1;
    if (state == S_DIVY) begin
      cmd.div_axis = 1'b1;
      cmd.div_start = !started;
      cmd.div_commit = started && !sts.div_busy;
    end
    cmd.cap_first  = (state == S_WAITY) && (phase == PH_TL_PRESS);
    cmd.cap_second = (state == S_WAITY) && (phase == PH_BR_PRESS);
    cmd.map_start  = (state == S_MAP) && !started;
  end

  // S_WAITY is the generic "decode latched item" state.
  tcm_in_t it;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READY; phase <= PH_IDLE; started <= 1'b0;
      out_valid <= 1'b0; out_pressed <= 1'b0; out_cal <= 1'b0; out_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_READY: if (accept) begin it <= in_item; state <= S_WAITY; end
        S_WAITY: begin
          started <= 1'b0;
          out_pressed <= 1'b0; out_done <= 1'b0;
          if (it.operation == OpStart) begin
            phase <= PH_TL_PRESS; out_cal <= 1'b1; state <= S_OUT;
          end else begin
            unique case (phase)
              PH_TL_PRESS: begin
                if (it.touched) phase <= PH_TL_RELEASE;
                out_cal <= 1'b1; state <= S_OUT;
              end
              PH_TL_RELEASE: begin
                if (!it.touched) phase <= PH_BR_PRESS;
                out_cal <= 1'b1; state <= S_OUT;
              end
              PH_BR_PRESS: begin
                if (it.touched) phase <= PH_BR_RELEASE;
                out_cal <= 1'b1; state <= S_OUT;
              end
              PH_BR_RELEASE: begin
                if (!it.touched) begin
                  state <= S_DIVX;
                end else begin
                  out_cal <= 1'b1; state <= S_OUT;
                end
              end
              default: begin
                out_cal <= 1'b0;
                if (it.touched) begin out_pressed <= 1'b1; state <= S_MAP; end
                else state <= S_OUT;
              end
            endcase
          end
        end
        S_DIVX: begin
          if (!started) started <= 1'b1;
          else if (!sts.div_busy) begin started <= 1'b0; state <= S_DIVY; end
        end
        S_DIVY: begin
          if (!started) started <= 1'b1;
          else if (!sts.div_busy) begin
            started <= 1'b0; phase <= PH_IDLE; out_cal <= 1'b0; out_done <= 1'b1;
            state <= S_OUT;
          end
        end
        S_MAP: begin
          if (!started) started <= 1'b1;
          else if (!sts.map_busy) begin started <= 1'b0; state <= S_OUT; end
        end
        S_OUT: begin out_valid <= 1'b1; state <= S_READY; end
        default: state <= S_READY;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> !out_cal) else $error("done while calibrating");
  a_press_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pressed |-> !out_cal && !out_done) else $error("pressed in cal");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_READY |-> !in_ready) else $error("ready while busy");
`endif

endmodule
`default_nettype wire

@@ rtl/touch_two_point_calibrated_mapper_top.sv @@
// Top level of the two-point calibrated touch mapper.
//
// Channel   Direction  Payload
// in_ch     sink       operation, touched, raw_x, raw_y
// out_ch    source     pressed, pixel_x, pixel_y, calibrating, calibration_done
//
// An item is accepted only when the block is free and no result is pending.
// From acceptance, a poll passes through the decode and output states; a touch
// is also mapped first, and the item that completes calibration first runs the
// one-bit-per-cycle restoring divider for each axis in turn.
// Reset returns to uncalibrated (scales zero) with calibration idle.
// A stalled result holds; the next item waits until it is taken.
`default_nettype none
module touch_two_point_calibrated_mapper_top
  import tcm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  tcm_if.sink      in_ch,
  tcm_if.source    out_ch
);

  tcm_cmd_t cmd;
  tcm_sts_t sts;
  logic pressed, cal, done;
  logic [PixXW-1:0] px;
  logic [PixYW-1:0] py;

  tcm_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_pressed(pressed), .out_cal(cal), .out_done(done),
    .sts, .cmd
  );

  tcm_datapath u_dp (
    .clk, .rst, .in_item(in_ch.data), .cmd, .sts, .pix_x(px), .pix_y(py)
  );

  // Pixel fields read zero when no touch point is reported.
  always_comb begin
    out_ch.data.pressed          = pressed;
    out_ch.data.pixel_x          = pressed ? px : '0;
    out_ch.data.pixel_y          = pressed ? py : '0;
    out_ch.data.calibrating      = cal;
    out_ch.data.calibration_done = done;
  end

endmodule
`default_nettype wire
